@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: beat layouts,
// command codes and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default screen geometry
	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;

	// character and attribute codes
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'd7;

	// command codes
	typedef enum logic [1:0] {
		CMD_PUT_CUR = 2'd0,
		CMD_PUT_POS = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	// input beat
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_code;
		logic [7:0] cell_color;
		logic [6:0] column_in;
		logic [4:0] row_in;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic [15:0] read_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic        line_done;
		logic [4:0]  line_row;
		logic        scrolled;
		logic        redraw;
	} out_item_t;

endpackage

@@ design/tcw_screen_mem.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// Cells are laid out as {row, column} so a row starts on a power-of-two.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(ROWS)+$clog2(COLS)-1:0] waddr,
	input  logic [15:0] wdata,
	input  logic re,
	input  logic [$clog2(ROWS)+$clog2(COLS)-1:0] raddr,
	output logic [15:0] rdata
);
	localparam int COL_W = $clog2(COLS);
	localparam int DEPTH = ROWS << COL_W;

	logic [15:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor registers, cell writes and reads, the scroll copy
// sweep and the blanking sweep used for reset, clear and the bottom row.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  tcw_pkg::in_item_t in_data,
	output logic in_stall,
	input  logic [7:0] text_color,
	input  logic out_free,
	output logic res_valid,
	output tcw_pkg::out_item_t res,
	output logic mem_we,
	output logic [$clog2(ROWS)+$clog2(COLS)-1:0] mem_waddr,
	output logic [15:0] mem_wdata,
	output logic mem_re,
	output logic [$clog2(ROWS)+$clog2(COLS)-1:0] mem_raddr,
	input  logic [15:0] mem_rdata
);
	import tcw_pkg::*;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [ROW_W-1:0] PENULT_ROW = ROW_W'(ROWS - 2);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_RDWAIT = 6'b000100,
		S_SCROLL = 6'b001000,
		S_BLANK  = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [ROW_W-1:0] crow_q;
	logic [COL_W-1:0] ccol_q;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic scan_done_q, scan_done_d;
	logic cp_valid_s1;
	logic [ADDR_W-1:0] cp_addr_s1;
	logic cp_issue;
	logic [7:0] blank_color_q, blank_color_d;
	logic want_res_q, want_res_d;
	out_item_t res_q;
	logic res_ld;
	out_item_t res_ld_val;

	// decode of the held item
	logic in_range;
	logic is_nl, wrap, end_line, last_row, do_scroll;
	logic [COL_W:0] col_inc;
	logic [ROW_W-1:0] new_row;
	logic [COL_W-1:0] new_col;
	logic cur_update;
	out_item_t res_now;

	always_comb begin
		in_range = ({1'b0, item_q.column_in} < 8'(COLS)) &&
			({1'b0, item_q.row_in} < 6'(ROWS));
		is_nl    = item_q.char_code == NEWLINE_CODE;
		col_inc  = {1'b0, ccol_q} + 1'b1;
		wrap     = !is_nl && (col_inc == (COL_W+1)'(COLS));
		end_line = is_nl || wrap;
		last_row = crow_q == LAST_ROW;
		do_scroll = end_line && last_row;
		if (end_line) begin
			new_row = last_row ? crow_q : crow_q + 1'b1;
			new_col = '0;
		end else begin
			new_row = crow_q;
			new_col = col_inc[COL_W-1:0];
		end
	end

	// result for the held item, cursor as it stands after the item
	always_comb begin
		res_now = '0;
		res_now.cursor_row = 5'(crow_q);
		res_now.cursor_col = 7'(ccol_q);
		unique case (cmd_t'(item_q.command))
			CMD_PUT_CUR: begin
				res_now.cursor_row = 5'(new_row);
				res_now.cursor_col = 7'(new_col);
				res_now.line_done  = end_line;
				res_now.line_row   = end_line ? 5'(crow_q) : 5'd0;
				res_now.scrolled   = do_scroll;
				res_now.redraw     = do_scroll;
			end
			CMD_CLEAR: begin
				res_now.redraw = 1'b1;
			end
			CMD_READ: begin
				res_now.read_data = in_range ? mem_rdata : 16'd0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d       = state_q;
		row_d         = row_q;
		col_d         = col_q;
		scan_done_d   = scan_done_q;
		blank_color_d = blank_color_q;
		want_res_d    = want_res_q;
		res_valid     = 1'b0;
		res           = res_q;
		res_ld        = 1'b0;
		res_ld_val    = res_now;
		cur_update    = 1'b0;
		cp_issue      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = '0;
		mem_wdata     = '0;
		mem_re        = 1'b0;
		mem_raddr     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_t'(item_q.command))
					CMD_PUT_CUR: begin
						cur_update = 1'b1;
						mem_we     = !is_nl;
						mem_waddr  = {crow_q, ccol_q};
						mem_wdata  = {text_color, item_q.char_code};
						if (do_scroll) begin
							res_ld        = 1'b1;
							row_d         = '0;
							col_d         = '0;
							scan_done_d   = 1'b0;
							blank_color_d = text_color;
							want_res_d    = 1'b1;
							state_d       = S_SCROLL;
						end else begin
							res_valid = 1'b1;
							res       = res_now;
						end
					end
					CMD_PUT_POS: begin
						mem_we    = in_range;
						mem_waddr = {item_q.row_in[ROW_W-1:0], item_q.column_in[COL_W-1:0]};
						mem_wdata = {item_q.cell_color, item_q.char_code};
						res_valid = 1'b1;
						res       = res_now;
					end
					CMD_CLEAR: begin
						res_ld        = 1'b1;
						row_d         = '0;
						col_d         = '0;
						blank_color_d = text_color;
						want_res_d    = 1'b1;
						state_d       = S_BLANK;
					end
					CMD_READ: begin
						mem_re    = in_range;
						mem_raddr = {item_q.row_in[ROW_W-1:0], item_q.column_in[COL_W-1:0]};
						state_d   = S_RDWAIT;
					end
					default: begin
					end
				endcase
				if (res_valid) begin
					res_ld  = !out_free;
					state_d = out_free ? S_IDLE : S_FIN;
				end
			end
			S_RDWAIT: begin
				res_valid = 1'b1;
				res       = res_now;
				res_ld    = !out_free;
				state_d   = out_free ? S_IDLE : S_FIN;
			end
			S_SCROLL: begin
				// read the row below, write it into this row in the following cycle
				mem_we    = cp_valid_s1;
				mem_waddr = cp_addr_s1;
				mem_wdata = mem_rdata;
				if (!scan_done_q) begin
					cp_issue  = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = {row_q + 1'b1, col_q};
					if (col_q == LAST_COL) begin
						col_d = '0;
						if (row_q == PENULT_ROW) begin
							scan_done_d = 1'b1;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end else begin
					row_d   = LAST_ROW;
					col_d   = '0;
					state_d = S_BLANK;
				end
			end
			S_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = {row_q, col_q};
				mem_wdata = {blank_color_q, BLANK_CODE};
				if (col_q == LAST_COL) begin
					col_d = '0;
					if (row_q == LAST_ROW) begin
						state_d = want_res_q ? S_FIN : S_IDLE;
					end else begin
						row_d = row_q + 1'b1;
					end
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			S_FIN: begin
				res_valid = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// control registers; reset starts the blanking pass in the reset colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_BLANK;
			row_q         <= '0;
			col_q         <= '0;
			scan_done_q   <= 1'b0;
			blank_color_q <= RESET_COLOR;
			want_res_q    <= 1'b0;
			crow_q        <= '0;
			ccol_q        <= '0;
			cp_valid_s1   <= 1'b0;
		end else begin
			state_q       <= state_d;
			row_q         <= row_d;
			col_q         <= col_d;
			scan_done_q   <= scan_done_d;
			blank_color_q <= blank_color_d;
			want_res_q    <= want_res_d;
			cp_valid_s1   <= cp_issue;
			if (cur_update) begin
				crow_q <= new_row;
				ccol_q <= new_col;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (res_ld) begin
			res_q <= res_ld_val;
		end
		cp_addr_s1 <= {row_q, col_q};
	end

	// cursor always inside the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(crow_q) < ROWS) && (32'(ccol_q) < COLS))
		else $error("cursor outside screen");

	// a copy write only follows a read issued in the scroll sweep
	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> state_q == S_SCROLL)
		else $error("copy write outside scroll sweep");

	// the read port never hits the cell being written
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && mem_we) |-> mem_raddr != mem_waddr)
		else $error("read and write to the same cell");

	// an accepted beat is worked on in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> state_q == S_EXEC)
		else $error("accepted beat not executed");

	// a scroll leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.scrolled) |->
		(32'(res.cursor_row) == ROWS - 1) && (res.cursor_col == 7'd0))
		else $error("cursor wrong after scroll");

endmodule

@@ design/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console writer: a COLS x ROWS store of 16-bit cells (colour above
// character) with a cursor, taking put, put-at, clear and read commands.
//
// Channels: in_valid/in_stall/in_data carries one command beat; out_valid/
// out_stall/out_data carries exactly one result beat per command.
// cfg_valid/cfg_ready/cfg_data writes the text colour; cfg_ready is always
// high and the colour should only change while no command is in flight.
// Sequence: a put or put-at beat is executed in the state after acceptance
// and its result goes to the output register; a read first passes through a
// wait state for the registered store read. A new beat is taken only in the
// idle state. A newline or wrap on the last row scrolls: a read-then-write
// copy of each row into the one above through the single store port pair,
// then a blanking of the bottom row. A clear writes ROWS*COLS cells, one
// per cycle. The next command is taken once the current one has handed
// over its result.
// Reset: the cursor goes home, the colour returns to 7 and a blanking pass
// writes spaces in colour 7 to every cell; in_stall is high meanwhile.
// A stalled result stays in the output register; one further command may
// finish its work and then waits for that register to drain.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
	parameter int COLS = tcw_pkg::DEF_COLS,
	parameter int ROWS = tcw_pkg::DEF_ROWS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tcw_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output tcw_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data
);
	import tcw_pkg::*;

	localparam int ADDR_W = $clog2(ROWS) + $clog2(COLS);

	logic [7:0] text_color_q;
	logic out_valid_q;
	out_item_t out_data_q;
	logic out_free;
	logic res_valid;
	out_item_t res;
	logic mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [15:0] mem_wdata, mem_rdata;

	// colour register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// command sequencer
	tcw_ctrl #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_data(in_data),
		.in_stall(in_stall),
		.text_color(text_color_q),
		.out_free(out_free),
		.res_valid(res_valid),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// screen store
	tcw_screen_mem #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
